// File: rtl/tpdl_pkg.sv
// Shared constants, codes and state encoding for the tree path distance / LCA block.
package tpdl_pkg;

   localparam int DEF_MAX_NODES   = 65536;
   localparam int DEF_JUMP_LEVELS = 16;
   localparam int DEF_EDGE_BITS   = 30;

   localparam int TYPE_W   = 2;
   localparam int NODE_W   = 16;
   localparam int EDGE_W   = 30;
   localparam int DEPTH_W  = 16;
   localparam int STATUS_W = 2;
   localparam int PATH_W   = 47;

   typedef enum logic [TYPE_W-1:0] {
      REQ_CLEAR = 2'd0,
      REQ_ADD   = 2'd1,
      REQ_QUERY = 2'd2
   } req_kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK            = 2'd0,
      STAT_PARENT_ABSENT = 2'd1,
      STAT_NODE_TAKEN    = 2'd2,
      STAT_QUERY_ABSENT  = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_ADD_RB,
      ST_ADD_RA,
      ST_ADD_CHK,
      ST_ADD_DIST,
      ST_ADD_ARD,
      ST_ADD_AWR,
      ST_Q_RA,
      ST_Q_RB,
      ST_Q_CHK,
      ST_L1_RD,
      ST_L1_DEP,
      ST_L1_CMP,
      ST_L1_END,
      ST_L2_RX,
      ST_L2_RY,
      ST_L2_CMP,
      ST_FIN_RD,
      ST_FIN,
      ST_D_SUM,
      ST_D_SUB1,
      ST_D_SUB2,
      ST_DONE
   } state_type;

endpackage

// File: rtl/tree_path_distance_lca_top.sv
// Weighted tree with binary-lifting lowest common ancestor and path length queries.
//
//  channel | ports                                              | direction
//  --------+----------------------------------------------------+----------
//  req     | req_valid req_ready req_type req_node_a/_b edge    | in
//  rsp     | rsp_valid rsp_ready rsp_status rsp_lca_node path   | out
//
// Sequencing per word:
//   add: one ancestor table read per level above level 0;
//   query: two lifting passes through the
//   single ancestor read port, one shared adder for compares and the distance sum;
//   clear: a pass over the presence flags, one entry a cycle.
// After reset the same presence pass runs with req_ready low.
// A finished word waits in the rsp register; the next req word is taken meanwhile
// and its result is held until the rsp register frees up.
module tree_path_distance_lca_top
   import tpdl_pkg::*;
#(
   parameter int MAX_NODES   = DEF_MAX_NODES,
   parameter int JUMP_LEVELS = DEF_JUMP_LEVELS,
   parameter int EDGE_BITS   = DEF_EDGE_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [TYPE_W-1:0]   req_type,
   input  logic [NODE_W-1:0]   req_node_a,
   input  logic [NODE_W-1:0]   req_node_b,
   input  logic [EDGE_W-1:0]   req_edge_len,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [STATUS_W-1:0] rsp_status,
   output logic [NODE_W-1:0]   rsp_lca_node,
   output logic [PATH_W-1:0]   rsp_path_distance
);

   // Node indices at or above NODE_SPAN count as absent.
   localparam int NODE_SPAN = (MAX_NODES < 65536) ? MAX_NODES : 65536;
   localparam int NB        = $clog2(NODE_SPAN);
   localparam int KB        = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
   localparam int EW        = (EDGE_BITS < EDGE_W) ? EDGE_BITS : EDGE_W;
   localparam int DW        = DEPTH_W + EDGE_BITS;
   localparam int AW        = (DW > PATH_W) ? DW : PATH_W;
   localparam int ANC_W     = NB + 1;           // valid bit on top of the node
   localparam int ANC_DEPTH = NODE_SPAN * (2 ** KB);

   function automatic logic node_in_range(input logic [NODE_W-1:0] n);
      return ({1'b0, n} < (NODE_W + 1)'(NODE_SPAN));
   endfunction

   // ------------------------------------------------------------------
   // Tables. Node 0 (root) is never written in depth, distance or
   // ancestor tables: reads at the root are forced to zero / invalid.
   // ------------------------------------------------------------------
   logic             pres_mem  [NODE_SPAN];
   logic [DEPTH_W-1:0] depth_mem [NODE_SPAN];
   logic [DW-1:0]    dist_mem  [NODE_SPAN];
   logic [ANC_W-1:0] anc_mem   [ANC_DEPTH];

   logic             pres_re, pres_we, pres_wdata;
   logic [NB-1:0]    pres_raddr, pres_waddr;
   logic             depth_re, depth_we;
   logic [NB-1:0]    depth_raddr;
   logic [DEPTH_W-1:0] depth_wdata;
   logic             dist_re, dist_we;
   logic [NB-1:0]    dist_raddr;
   logic [DW-1:0]    dist_wdata;
   logic             anc_re, anc_we;
   logic [NB-1:0]    anc_rnode, anc_wnode;
   logic [KB-1:0]    anc_rlvl, anc_wlvl;
   logic [ANC_W-1:0] anc_wdata;

   // request payload; node_a also addresses the depth and distance writes
   logic [NODE_W-1:0]  node_a_ff, node_a_in, node_b_ff, node_b_in;

   logic             pres_q_ff;
   logic [DEPTH_W-1:0] depth_q_ff;
   logic [DW-1:0]    dist_q_ff;
   logic [ANC_W-1:0] anc_q_ff;
   logic             depth_root_ff, dist_root_ff, anc_root_ff;

   logic [DEPTH_W-1:0] depth_val;
   logic [DW-1:0]    dist_val;
   logic [ANC_W-1:0] anc_val;

   always_ff @(posedge clock) begin
      if (pres_we) begin
         pres_mem[pres_waddr] <= pres_wdata;
      end
      if (pres_re) begin
         pres_q_ff <= pres_mem[pres_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (depth_we) begin
         depth_mem[node_a_ff[NB-1:0]] <= depth_wdata;
      end
      if (depth_re) begin
         depth_q_ff    <= depth_mem[depth_raddr];
         depth_root_ff <= (depth_raddr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (dist_we) begin
         dist_mem[node_a_ff[NB-1:0]] <= dist_wdata;
      end
      if (dist_re) begin
         dist_q_ff    <= dist_mem[dist_raddr];
         dist_root_ff <= (dist_raddr == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (anc_we) begin
         anc_mem[{anc_wnode, anc_wlvl}] <= anc_wdata;
      end
      if (anc_re) begin
         anc_q_ff    <= anc_mem[{anc_rnode, anc_rlvl}];
         anc_root_ff <= (anc_rnode == '0);
      end
   end

   assign depth_val = depth_root_ff ? '0 : depth_q_ff;
   assign dist_val  = dist_root_ff  ? '0 : dist_q_ff;
   assign anc_val   = anc_root_ff   ? '0 : anc_q_ff;

   // ------------------------------------------------------------------
   // Shared adder / subtractor. On subtract, carry out means a >= b.
   // ------------------------------------------------------------------
   logic [AW-1:0] alu_a, alu_b, alu_res;
   logic          alu_sub, alu_carry;
   logic [AW:0]   alu_sum;

   assign alu_sum   = {1'b0, alu_a} + {1'b0, (alu_sub ? ~alu_b : alu_b)} + (AW + 1)'(alu_sub);
   assign alu_res   = alu_sum[AW-1:0];
   assign alu_carry = alu_sum[AW];

   // ------------------------------------------------------------------
   // Sequencer registers
   // ------------------------------------------------------------------
   state_type          state_ff, state_in;
   logic [NB-1:0]      sweep_ff, sweep_in;
   logic               sweep_rsp_ff, sweep_rsp_in;
   logic [EW-1:0]      len_ff, len_in;
   logic [NB-1:0]      x_ff, x_in, y_ff, y_in;
   logic [DEPTH_W-1:0] dep_ff, dep_in, depth_y_ff, depth_y_in;
   logic [DW-1:0]      dist_a_ff, dist_a_in, dist_b_ff, dist_b_in;
   logic [AW-1:0]      acc_ff, acc_in;
   logic [ANC_W-1:0]   cur_ff, cur_in;
   logic [KB-1:0]      lvl_ff, lvl_in;
   logic               a_ok_ff, a_ok_in;
   status_type         res_status_ff, res_status_in;
   logic [NB-1:0]      res_lca_ff, res_lca_in;
   logic [PATH_W-1:0]  res_path_ff, res_path_in;
   logic               rsp_valid_ff, rsp_valid_in;
   status_type         rsp_status_ff, rsp_status_in;
   logic [NODE_W-1:0]  rsp_lca_ff, rsp_lca_in;
   logic [PATH_W-1:0]  rsp_path_ff, rsp_path_in;

   logic lvl_zero, lvl_last;
   assign lvl_zero = (lvl_ff == '0);
   assign lvl_last = (lvl_ff == KB'(JUMP_LEVELS - 1));

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      sweep_in      = sweep_ff;
      sweep_rsp_in  = sweep_rsp_ff;
      node_a_in     = node_a_ff;
      node_b_in     = node_b_ff;
      len_in        = len_ff;
      x_in          = x_ff;
      y_in          = y_ff;
      dep_in        = dep_ff;
      depth_y_in    = depth_y_ff;
      dist_a_in     = dist_a_ff;
      dist_b_in     = dist_b_ff;
      acc_in        = acc_ff;
      cur_in        = cur_ff;
      lvl_in        = lvl_ff;
      a_ok_in       = a_ok_ff;
      res_status_in = res_status_ff;
      res_lca_in    = res_lca_ff;
      res_path_in   = res_path_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_lca_in    = rsp_lca_ff;
      rsp_path_in   = rsp_path_ff;

      pres_re     = 1'b0;
      pres_raddr  = node_a_ff[NB-1:0];
      pres_we     = 1'b0;
      pres_waddr  = node_a_ff[NB-1:0];
      pres_wdata  = 1'b1;
      depth_re    = 1'b0;
      depth_raddr = node_a_ff[NB-1:0];
      depth_we    = 1'b0;
      dist_re     = 1'b0;
      dist_raddr  = node_a_ff[NB-1:0];
      dist_we     = 1'b0;
      anc_re      = 1'b0;
      anc_rnode   = x_ff;
      anc_rlvl    = lvl_ff;
      anc_we      = 1'b0;
      anc_wnode   = node_a_ff[NB-1:0];
      anc_wlvl    = lvl_ff;
      anc_wdata   = '0;

      alu_a   = '0;
      alu_b   = '0;
      alu_sub = 1'b0;

      depth_wdata = alu_res[DEPTH_W-1:0];
      dist_wdata  = alu_res[DW-1:0];

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_SWEEP: begin
            // presence pass: only the root stays marked
            pres_we    = 1'b1;
            pres_waddr = sweep_ff;
            pres_wdata = (sweep_ff == '0);
            if (sweep_ff == NB'(NODE_SPAN - 1)) begin
               state_in = sweep_rsp_ff ? ST_DONE : ST_IDLE;
            end else begin
               sweep_in = sweep_ff + NB'(1);
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               node_a_in     = req_node_a;
               node_b_in     = req_node_b;
               len_in        = req_edge_len[EW-1:0];
               res_status_in = STAT_OK;
               res_lca_in    = '0;
               res_path_in   = '0;
               case (req_type)
                  REQ_CLEAR: begin
                     sweep_in     = '0;
                     sweep_rsp_in = 1'b1;
                     state_in     = ST_SWEEP;
                  end
                  REQ_ADD:   state_in = ST_ADD_RB;
                  REQ_QUERY: state_in = ST_Q_RA;
                  default:   state_in = ST_DONE;
               endcase
            end
         end
         ST_ADD_RB: begin
            pres_re     = 1'b1;
            pres_raddr  = node_b_ff[NB-1:0];
            depth_re    = 1'b1;
            depth_raddr = node_b_ff[NB-1:0];
            dist_re     = 1'b1;
            dist_raddr  = node_b_ff[NB-1:0];
            state_in    = ST_ADD_RA;
         end
         ST_ADD_RA: begin
            dep_in    = depth_val;
            dist_a_in = dist_val;
            pres_re   = 1'b1;
            if (!(node_in_range(node_b_ff) && pres_q_ff)) begin
               res_status_in = STAT_PARENT_ABSENT;
               state_in      = ST_DONE;
            end else begin
               state_in = ST_ADD_CHK;
            end
         end
         ST_ADD_CHK: begin
            if (node_a_ff == '0 || !node_in_range(node_a_ff) || pres_q_ff) begin
               res_status_in = STAT_NODE_TAKEN;
               state_in      = ST_DONE;
            end else begin
               pres_we   = 1'b1;
               alu_a     = AW'(dep_ff);
               alu_b     = AW'(1);
               depth_we  = 1'b1;
               anc_we    = 1'b1;
               anc_wlvl  = '0;
               anc_wdata = {1'b1, node_b_ff[NB-1:0]};
               cur_in    = {1'b1, node_b_ff[NB-1:0]};
               lvl_in    = KB'(1);
               state_in  = ST_ADD_DIST;
            end
         end
         ST_ADD_DIST: begin
            alu_a   = AW'(dist_a_ff);
            alu_b   = AW'(len_ff);
            dist_we = 1'b1;
            state_in = (JUMP_LEVELS == 1) ? ST_DONE : ST_ADD_ARD;
         end
         ST_ADD_ARD: begin
            // ancestor 2^k = ancestor 2^(k-1) of ancestor 2^(k-1)
            anc_re    = cur_ff[NB];
            anc_rnode = cur_ff[NB-1:0];
            anc_rlvl  = lvl_ff - KB'(1);
            state_in  = ST_ADD_AWR;
         end
         ST_ADD_AWR: begin
            anc_we    = 1'b1;
            anc_wdata = cur_ff[NB] ? anc_val : '0;
            cur_in    = cur_ff[NB] ? anc_val : '0;
            if (lvl_last) begin
               state_in = ST_DONE;
            end else begin
               lvl_in   = lvl_ff + KB'(1);
               state_in = ST_ADD_ARD;
            end
         end
         ST_Q_RA: begin
            pres_re  = 1'b1;
            depth_re = 1'b1;
            dist_re  = 1'b1;
            state_in = ST_Q_RB;
         end
         ST_Q_RB: begin
            a_ok_in     = node_in_range(node_a_ff) && pres_q_ff;
            dep_in      = depth_val;
            dist_a_in   = dist_val;
            pres_re     = 1'b1;
            pres_raddr  = node_b_ff[NB-1:0];
            depth_re    = 1'b1;
            depth_raddr = node_b_ff[NB-1:0];
            dist_re     = 1'b1;
            dist_raddr  = node_b_ff[NB-1:0];
            state_in    = ST_Q_CHK;
         end
         ST_Q_CHK: begin
            if (!(a_ok_ff && node_in_range(node_b_ff) && pres_q_ff)) begin
               res_status_in = STAT_QUERY_ABSENT;
               state_in      = ST_DONE;
            end else begin
               dist_b_in = dist_val;
               alu_a     = AW'(dep_ff);
               alu_b     = AW'(depth_val);
               alu_sub   = 1'b1;
               // x takes the deeper node
               if (!alu_carry) begin
                  x_in       = node_b_ff[NB-1:0];
                  y_in       = node_a_ff[NB-1:0];
                  depth_y_in = dep_ff;
               end else begin
                  x_in       = node_a_ff[NB-1:0];
                  y_in       = node_b_ff[NB-1:0];
                  depth_y_in = depth_val;
               end
               lvl_in   = KB'(JUMP_LEVELS - 1);
               state_in = ST_L1_RD;
            end
         end
         ST_L1_RD: begin
            anc_re   = 1'b1;
            state_in = ST_L1_DEP;
         end
         ST_L1_DEP: begin
            cur_in      = anc_val;
            depth_re    = anc_val[NB];
            depth_raddr = anc_val[NB-1:0];
            if (anc_val[NB]) begin
               state_in = ST_L1_CMP;
            end else if (lvl_zero) begin
               state_in = ST_L1_END;
            end else begin
               lvl_in   = lvl_ff - KB'(1);
               state_in = ST_L1_RD;
            end
         end
         ST_L1_CMP: begin
            alu_a   = AW'(depth_val);
            alu_b   = AW'(depth_y_ff);
            alu_sub = 1'b1;
            if (alu_carry) begin
               x_in = cur_ff[NB-1:0];
            end
            if (lvl_zero) begin
               state_in = ST_L1_END;
            end else begin
               lvl_in   = lvl_ff - KB'(1);
               state_in = ST_L1_RD;
            end
         end
         ST_L1_END: begin
            if (x_ff == y_ff) begin
               res_lca_in = x_ff;
               dist_re    = 1'b1;
               dist_raddr = x_ff;
               state_in   = ST_D_SUM;
            end else begin
               lvl_in   = KB'(JUMP_LEVELS - 1);
               state_in = ST_L2_RX;
            end
         end
         ST_L2_RX: begin
            anc_re   = 1'b1;
            state_in = ST_L2_RY;
         end
         ST_L2_RY: begin
            cur_in    = anc_val;
            anc_re    = 1'b1;
            anc_rnode = y_ff;
            state_in  = ST_L2_CMP;
         end
         ST_L2_CMP: begin
            if (cur_ff != anc_val) begin
               x_in = cur_ff[NB-1:0];
               y_in = anc_val[NB-1:0];
            end
            if (lvl_zero) begin
               state_in = ST_FIN_RD;
            end else begin
               lvl_in   = lvl_ff - KB'(1);
               state_in = ST_L2_RX;
            end
         end
         ST_FIN_RD: begin
            anc_re   = 1'b1;
            anc_rlvl = '0;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            res_lca_in = anc_val[NB-1:0];
            dist_re    = 1'b1;
            dist_raddr = anc_val[NB-1:0];
            state_in   = ST_D_SUM;
         end
         ST_D_SUM: begin
            alu_a    = AW'(dist_a_ff);
            alu_b    = AW'(dist_b_ff);
            acc_in   = alu_res;
            state_in = ST_D_SUB1;
         end
         ST_D_SUB1: begin
            alu_a    = acc_ff;
            alu_b    = AW'(dist_val);
            alu_sub  = 1'b1;
            acc_in   = alu_res;
            state_in = ST_D_SUB2;
         end
         ST_D_SUB2: begin
            alu_a       = acc_ff;
            alu_b       = AW'(dist_val);
            alu_sub     = 1'b1;
            res_path_in = alu_res[PATH_W-1:0];
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_lca_in    = NODE_W'(res_lca_ff);
               rsp_path_in   = res_path_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload and work registers
   always_ff @(posedge clock) begin
      node_a_ff     <= node_a_in;
      node_b_ff     <= node_b_in;
      len_ff        <= len_in;
      x_ff          <= x_in;
      y_ff          <= y_in;
      dep_ff        <= dep_in;
      depth_y_ff    <= depth_y_in;
      dist_a_ff     <= dist_a_in;
      dist_b_ff     <= dist_b_in;
      acc_ff        <= acc_in;
      cur_ff        <= cur_in;
      lvl_ff        <= lvl_in;
      a_ok_ff       <= a_ok_in;
      res_status_ff <= res_status_in;
      res_lca_ff    <= res_lca_in;
      res_path_ff   <= res_path_in;
      rsp_status_ff <= rsp_status_in;
      rsp_lca_ff    <= rsp_lca_in;
      rsp_path_ff   <= rsp_path_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_lca_node      = rsp_lca_ff;
   assign rsp_path_distance = rsp_path_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   a_reset_sweeps: assert property (@(posedge clock)
      $fell(reset) |-> (state_ff == ST_SWEEP))
      else $error("presence pass not started after reset");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("rsp word loaded outside the done step");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (rsp_status_ff != STAT_OK) |->
         (rsp_lca_ff == '0) && (rsp_path_ff == '0))
      else $error("rejected word carries nonzero lca or distance");

   a_mark_only_added: assert property (@(posedge clock) disable iff (reset)
      pres_we && pres_wdata && (pres_waddr != '0) |-> (state_ff == ST_ADD_CHK))
      else $error("node marked present outside an add");

   a_lvl_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_L1_RD || state_ff == ST_L2_RX || state_ff == ST_ADD_ARD)
         |-> (lvl_ff <= KB'(JUMP_LEVELS - 1)))
      else $error("lifting level beyond table depth");

endmodule

// File: bench/testbench.sv
// Self-checking bench for the weighted tree block: lowest common ancestor and path length.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import tpdl_pkg::*;

   localparam int LEVELS        = DEF_JUMP_LEVELS;
   localparam int HALF_PERIOD   = 5;
   localparam int STALL_LIMIT   = 200000;  // longer than a clear or start-up sweep
   localparam int RANDOM_WORDS  = 1750;
   localparam int CLEAR_EVERY   = 600;
   localparam int MODE_SPAN     = 150;     // words per idling mode
   localparam int SETTLE_CYCLES = 150;
   localparam int MAX_GAP       = 12;

   // type code 3 carries no meaning; the block must answer it with all zeros
   localparam logic [TYPE_W-1:0] REQ_UNUSED = 2'd3;
   localparam logic [EDGE_W-1:0] EDGE_MAX   = '1;
   localparam logic [NODE_W-1:0] NODE_TOP   = '1;

   typedef struct packed {
      status_type        status;
      logic [NODE_W-1:0] lca;
      logic [PATH_W-1:0] path;
   } tree_answer_type;

   // Mirror of the tree plus the queue of answers still owed by the block.
   class lca_scoreboard_type;
      bit                 present[int unsigned];
      logic [DEPTH_W-1:0] depth_of[int unsigned];
      logic [45:0]        reach[int unsigned];   // distance from the root
      logic [16:0]        jump[int unsigned];    // {valid, node}, key node*LEVELS+k
      tree_answer_type    awaited[$];
      int                 failures;

      function new();
         failures = 0;
         reset_tree();
      endfunction

      function void reset_tree();
         present.delete();
         present[0]  = 1'b1;
         depth_of[0] = '0;
         reach[0]    = '0;
         for (int k = 0; k < LEVELS; k++) jump[k] = '0;
      endfunction

      function logic [16:0] up(logic [NODE_W-1:0] n, int k);
         return jump[int'(n) * LEVELS + k];
      endfunction

      function logic [NODE_W-1:0] lowest_common(logic [NODE_W-1:0] s, logic [NODE_W-1:0] t);
         logic [NODE_W-1:0] x, y;
         logic [16:0]       ja, jb;
         x = s;
         y = t;
         if (depth_of[x] < depth_of[y]) begin
            x = t;
            y = s;
         end
         // lift the deeper node to the other's depth
         for (int k = LEVELS - 1; k >= 0; k--) begin
            ja = up(x, k);
            if (ja[16] && depth_of[ja[15:0]] >= depth_of[y]) x = ja[15:0];
         end
         if (x == y) return x;
         // lift both while their ancestors still differ
         for (int k = LEVELS - 1; k >= 0; k--) begin
            ja = up(x, k);
            jb = up(y, k);
            if (ja != jb) begin
               x = ja[15:0];
               y = jb[15:0];
            end
         end
         ja = up(x, 0);
         return ja[15:0];
      endfunction

      function tree_answer_type compute_answer(logic [TYPE_W-1:0] kind,
                                               logic [NODE_W-1:0] a,
                                               logic [NODE_W-1:0] b,
                                               logic [EDGE_W-1:0] len);
         tree_answer_type   ans;
         logic [16:0]       prev;
         logic [NODE_W-1:0] l;
         logic [47:0]       sum;
         ans = '{STAT_OK, '0, '0};
         case (kind)
            REQ_CLEAR: reset_tree();
            REQ_ADD: begin
               if (!present.exists(b)) begin
                  ans.status = STAT_PARENT_ABSENT;
               end else if (a == 0 || present.exists(a)) begin
                  ans.status = STAT_NODE_TAKEN;
               end else begin
                  present[a]  = 1'b1;
                  depth_of[a] = depth_of[b] + 1'b1;
                  reach[a]    = reach[b] + len;
                  jump[int'(a) * LEVELS] = {1'b1, b};
                  for (int k = 1; k < LEVELS; k++) begin
                     prev = jump[int'(a) * LEVELS + k - 1];
                     jump[int'(a) * LEVELS + k] = prev[16] ? up(prev[15:0], k - 1) : '0;
                  end
               end
            end
            REQ_QUERY: begin
               if (!present.exists(a) || !present.exists(b)) begin
                  ans.status = STAT_QUERY_ABSENT;
               end else begin
                  l        = lowest_common(a, b);
                  sum      = {2'b0, reach[a]} + {2'b0, reach[b]} - {1'b0, reach[l], 1'b0};
                  ans.lca  = l;
                  ans.path = sum[PATH_W-1:0];
               end
            end
            default: ;
         endcase
         return ans;
      endfunction

      function void note_request(logic [TYPE_W-1:0] kind, logic [NODE_W-1:0] a,
                                 logic [NODE_W-1:0] b, logic [EDGE_W-1:0] len);
         tree_answer_type ans;
         ans     = compute_answer(kind, a, b, len);
         awaited = {awaited, ans};
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            failures++;
         end
      endfunction

      function void check_answer(logic [STATUS_W-1:0] status, logic [NODE_W-1:0] lca,
                                 logic [PATH_W-1:0] path_len);
         tree_answer_type ans;
         if (awaited.size() == 0) begin
            $display("%0t ns: unexpected result word, expected none, got %0h/%0h/%0h",
                     $time, status, lca, path_len);
            failures++;
            return;
         end
         ans = awaited.pop_front();
         compare_field("status", 64'(ans.status), 64'(status));
         compare_field("lca_node", 64'(ans.lca), 64'(lca));
         compare_field("path_distance", 64'(ans.path), 64'(path_len));
      endfunction

      function int outstanding();
         return awaited.size();
      endfunction
   endclass

   logic                clock        = 1'b0;
   logic                reset        = 1'b1;
   logic                req_valid    = 1'b0;
   logic                req_ready;
   logic [TYPE_W-1:0]   req_type     = '0;
   logic [NODE_W-1:0]   req_node_a   = '0;
   logic [NODE_W-1:0]   req_node_b   = '0;
   logic [EDGE_W-1:0]   req_edge_len = '0;
   logic                rsp_valid;
   logic                rsp_ready    = 1'b0;
   logic [STATUS_W-1:0] rsp_status;
   logic [NODE_W-1:0]   rsp_lca_node;
   logic [PATH_W-1:0]   rsp_path_distance;

   lca_scoreboard_type sb;

   // stimulus-side view of the tree: which nodes exist, in order of insertion
   bit                in_tree[int unsigned];
   logic [NODE_W-1:0] grown[$];
   bit                sender_quiet = 1'b0;

   tree_path_distance_lca_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_type          (req_type),
      .req_node_a        (req_node_a),
      .req_node_b        (req_node_b),
      .req_edge_len      (req_edge_len),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_lca_node      (rsp_lca_node),
      .rsp_path_distance (rsp_path_distance)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Monitor: both handshakes are sampled at the edge, before any bench NBA lands.
   // A request is noted before a response of the same edge is checked; FIFO order
   // keeps that safe since a word cannot finish in the cycle it is taken.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            sb.note_request(req_type, req_node_a, req_node_b, req_edge_len);
         if (rsp_valid && rsp_ready)
            sb.check_answer(rsp_status, rsp_lca_node, rsp_path_distance);
      end
   end

   function automatic logic [NODE_W-1:0] fresh_node();
      logic [NODE_W-1:0] n;
      do n = NODE_W'($urandom_range(1, 65535)); while (in_tree.exists(n));
      return n;
   endfunction

   function automatic logic [NODE_W-1:0] tree_member();
      return grown[$urandom_range(0, grown.size() - 1)];
   endfunction

   function automatic logic [EDGE_W-1:0] random_edge();
      case ($urandom_range(0, 3))
         0:       return EDGE_MAX;
         1:       return EDGE_W'($urandom_range(0, 15));
         default: return EDGE_W'($urandom);
      endcase
   endfunction

   function automatic void forget_tree();
      in_tree.delete();
      grown.delete();
      in_tree[0] = 1'b1;
      grown = {grown, NODE_W'(0)};
   endfunction

   // Present one word and hold it until taken. Valid is only dropped when a gap
   // is drawn, so back-to-back words keep valid high without a glitch.
   task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [NODE_W-1:0] a,
                               input logic [NODE_W-1:0] b, input logic [EDGE_W-1:0] len);
      int gap;
      gap = sender_quiet ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_type     <= kind;
      req_node_a   <= a;
      req_node_b   <= b;
      req_edge_len <= len;
      do @(posedge clock); while (!req_ready);
      // track what the tree now holds, so later words can be shaped around it
      if (kind == REQ_CLEAR) begin
         forget_tree();
      end else if (kind == REQ_ADD && in_tree.exists(b) && a != 0 && !in_tree.exists(a)) begin
         in_tree[a] = 1'b1;
         grown = {grown, a};
      end
   endtask

   // Hold off the sender until every owed answer is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (sb.outstanding() != 0);
   endtask

   // One random word: mostly tree growth and well-formed queries, the rest
   // rejected adds, queries on missing nodes and the meaningless type code.
   task automatic random_word();
      int                roll;
      logic [NODE_W-1:0] a, b;
      roll = $urandom_range(0, 99);
      if (roll < 45) begin
         // half the time hang under the newest node so paths get deep
         b = ($urandom_range(0, 1) == 1) ? grown[$] : tree_member();
         send_request(REQ_ADD, fresh_node(), b, random_edge());
      end else if (roll < 80) begin
         a = tree_member();
         case ($urandom_range(0, 7))
            0:       b = a;
            1:       b = '0;
            default: b = tree_member();
         endcase
         send_request(REQ_QUERY, a, b, EDGE_W'($urandom));
      end else if (roll < 85) begin
         send_request(REQ_ADD, NODE_W'($urandom), fresh_node(), random_edge());
      end else if (roll < 90) begin
         a = ($urandom_range(0, 3) == 0) ? '0 : tree_member();
         b = ($urandom_range(0, 1) == 1) ? a : tree_member();
         send_request(REQ_ADD, a, b, random_edge());
      end else if (roll < 96) begin
         a = tree_member();
         b = fresh_node();
         if ($urandom_range(0, 1) == 1) send_request(REQ_QUERY, a, b, EDGE_W'($urandom));
         else                           send_request(REQ_QUERY, b, a, EDGE_W'($urandom));
      end else begin
         send_request(REQ_UNUSED, NODE_W'($urandom), NODE_W'($urandom), EDGE_W'($urandom));
      end
   endtask

   // Result side: random stall before each word, with stretches of no stall.
   initial begin
      int stall;
      int taken;
      taken = 0;
      do @(posedge clock); while (reset);
      forever begin
         stall = ((taken / MODE_SPAN) % 3 == 2) ? 0 : $urandom_range(0, MAX_GAP);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         taken++;
      end
   end

   // Watchdog: ends the run if no word moves on either channel for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("%0t ns: no word moved for %0d cycles", $time, STALL_LIMIT);
      $display("FAIL tree_path_distance_lca_top");
      $finish;
   end

   initial begin
      sb = new();
      forget_tree();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: edge ids, root handling, every status code, clear and re-add.
      send_request(REQ_QUERY, 16'd0, 16'd0, '0);           // root with itself
      send_request(REQ_UNUSED, NODE_TOP, NODE_TOP, EDGE_MAX);
      send_request(REQ_ADD, 16'd0, 16'd0, 30'd5);          // root cannot be added
      send_request(REQ_ADD, 16'd5, 16'd7, 30'd5);          // parent missing
      send_request(REQ_ADD, 16'd1, 16'd1, 30'd3);          // self-parent, both missing
      send_request(REQ_ADD, NODE_TOP, 16'd0, EDGE_MAX);    // top id, longest edge
      send_request(REQ_ADD, 16'd1, NODE_TOP, '0);          // zero-length edge
      send_request(REQ_ADD, NODE_TOP, NODE_TOP, 30'd9);    // node equals parent
      send_request(REQ_ADD, 16'd2, 16'd1, 30'd1);
      send_request(REQ_ADD, 16'd3, 16'd0, EDGE_MAX);
      send_request(REQ_ADD, 16'd1, 16'd4, 30'd2);          // parent checked before node
      send_request(REQ_QUERY, 16'd2, 16'd3, '0);           // meet at the root
      send_request(REQ_QUERY, 16'd2, NODE_TOP, '0);        // ancestor of the other
      send_request(REQ_QUERY, NODE_TOP, 16'd2, EDGE_MAX);
      send_request(REQ_QUERY, 16'd2, 16'd2, '0);
      send_request(REQ_QUERY, 16'd0, 16'd2, '0);
      send_request(REQ_QUERY, 16'd4, 16'd0, '0);           // first node missing
      send_request(REQ_QUERY, 16'd0, 16'd4, '0);           // second node missing
      send_request(REQ_CLEAR, '0, '0, '0);
      send_request(REQ_QUERY, 16'd2, 16'd0, '0);           // gone after the clear
      send_request(REQ_ADD, 16'd2, 16'd0, 30'd77);         // same id comes back
      send_request(REQ_QUERY, 16'd2, 16'd0, '0);
      drain_results();

      // Random: the tree grows, is queried, and is cleared a couple of times
      // after the sender has fully drained.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         sender_quiet = ((i / MODE_SPAN) % 3 == 1);
         if (i > 0 && i % CLEAR_EVERY == 0) begin
            drain_results();
            send_request(REQ_CLEAR, NODE_W'($urandom), NODE_W'($urandom), EDGE_W'($urandom));
         end
         random_word();
      end

      drain_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0)
         $display("PASS tree_path_distance_lca_top");
      else
         $display("FAIL tree_path_distance_lca_top");
      $finish;
   end

endmodule

// File: tree_path_distance_lca_top.f
rtl/tpdl_pkg.sv
rtl/tree_path_distance_lca_top.sv
bench/testbench.sv
